>>> src/negp_pkg.sv
// Package with shared types and constants of the equal-group partition unit.
`timescale 1ns / 1ps
`default_nettype none
package negp_pkg;
  localparam int DEPTH = 32;
  localparam int AW = 5;
  localparam int LW = 5;
  localparam int CW = 5;
  localparam int MAX_N_DEF = 32;
  localparam logic [CW-1:0] GROUP_SIZE_RST = 5'd2;
  localparam logic [CW-1:0] NUM_GROUPS_RST = 5'd2;
  localparam logic [0:0] OP_WRITE = 1'b0;
  localparam logic [0:0] OP_ADVANCE = 1'b1;
  localparam logic [0:0] REG_GROUP_SIZE = 1'b0;
  localparam logic [0:0] REG_NUM_GROUPS = 1'b1;

  typedef struct packed {
    logic          re;
    logic [AW-1:0] raddr;
    logic          we;
    logic [AW-1:0] waddr;
    logic [LW-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic [CW-1:0] group_size;
    logic [CW-1:0] num_groups;
  } cfg_t;
endpackage
`default_nettype wire

>>> src/negp_mem.sv
// Arrangement store with registered read, write forwarding and reset-to-identity valid bits.
`timescale 1ns / 1ps
`default_nettype none
module negp_mem (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire negp_pkg::mem_req_t req,
  output logic [negp_pkg::LW-1:0] rdata
);
  import negp_pkg::*;
  logic [LW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [LW-1:0]    rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.we) begin
      valid_r[req.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      if (req.we && req.waddr == req.raddr) begin
        rdata_r <= req.wdata;
      end else if (valid_r[req.raddr]) begin
        rdata_r <= mem[req.raddr];
      end else begin
        rdata_r <= LW'(req.raddr);
      end
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

>>> src/negp_ctrl.sv
// Sequencer that runs the partition step on the store and streams the arrangement.
`timescale 1ns / 1ps
`default_nettype none
module negp_ctrl #(
  parameter int MAX_N = negp_pkg::MAX_N_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire negp_pkg::cfg_t      cfg,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_op,
  input  wire logic [negp_pkg::AW-1:0] in_position,
  input  wire logic [negp_pkg::LW-1:0] in_label,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [negp_pkg::AW-1:0]  out_position,
  output logic [negp_pkg::LW-1:0]  out_label,
  output logic                     out_has_next,
  output logic                     out_last,
  output negp_pkg::mem_req_t       mreq,
  input  wire logic [negp_pkg::LW-1:0] mrdata
);
  import negp_pkg::*;
  localparam int LIMIT = (MAX_N < DEPTH) ? MAX_N : DEPTH;

  localparam logic [4:0] S_IDLE = 5'd0,  S_APV = 5'd1,  S_AT = 5'd2,   S_ATC = 5'd3;
  localparam logic [4:0] S_AD = 5'd4,    S_SW0 = 5'd5,  S_SW1 = 5'd6,  S_SW2 = 5'd7;
  localparam logic [4:0] S_SW3 = 5'd8,   S_BTOP = 5'd9, S_BTIP = 5'd10, S_BPV = 5'd11;
  localparam logic [4:0] S_SI = 5'd12,   S_SV = 5'd13,  S_SJ = 5'd14,  S_SC = 5'd15;
  localparam logic [4:0] S_FCHK = 5'd16, S_FC = 5'd17,  S_RINIT = 5'd18, S_RA = 5'd19;
  localparam logic [4:0] S_RT = 5'd20,   S_RP = 5'd21,  S_RW = 5'd22,  S_ORD = 5'd23;
  localparam logic [4:0] S_OCAP = 5'd24;

  typedef logic signed [6:0] idx_t;

  logic [4:0]    state_r, state_nxt;
  idx_t          pivot_r, pivot_nxt, tail_r, tail_nxt, low_r, low_nxt;
  idx_t          succ_r, succ_nxt, span_r, span_nxt, si_r, si_nxt, j_r, j_nxt;
  idx_t          sa_r, sa_nxt, sb_r, sb_nxt, rend_r, rend_nxt, p_r, p_nxt;
  idx_t          n_r, n_nxt, g_r, g_nxt, rcnt_r, rcnt_nxt;
  logic [LW-1:0] pv_r, pv_nxt, tip_r, tip_nxt, t_r, t_nxt, v_r, v_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic          ok_r, ok_nxt, bad_r, bad_nxt, rot_r, rot_nxt;
  logic          ov_r, ov_nxt;
  logic [AW-1:0] opos_r, opos_nxt;
  logic [LW-1:0] olab_r, olab_nxt;
  logic          ohas_r, ohas_nxt, olast_r, olast_nxt;

  logic [9:0] prod;
  logic       cfg_bad;
  idx_t       gs, nn, rfirst, rmid, rend_c, rk, rlen;
  logic       accept, free, is_last;

  assign prod    = 10'(cfg.group_size) * 10'(cfg.num_groups);
  assign cfg_bad = (cfg.group_size == '0) || (cfg.num_groups < CW'(2)) || (prod > 10'(LIMIT));
  assign gs      = idx_t'(cfg.group_size);
  assign nn      = idx_t'(prod[6:0]);
  assign accept  = in_valid && !in_stall;
  assign free    = !ov_r || !out_stall;
  assign is_last = bad_r || (idx_t'({2'b0, i_r}) == n_r - idx_t'(1));
  assign rfirst  = pivot_r + idx_t'(1);
  assign rmid    = succ_r + idx_t'(1);
  assign rend_c  = (succ_r + span_r > n_r) ? n_r : succ_r + span_r;
  assign rk      = rmid - rfirst;
  assign rlen    = rend_c - rfirst;

  assign in_stall     = (state_r != S_IDLE);
  assign out_valid    = ov_r;
  assign out_position = opos_r;
  assign out_label    = olab_r;
  assign out_has_next = ohas_r;
  assign out_last     = olast_r;

  always_comb begin
    state_nxt = state_r;
    pivot_nxt = pivot_r; tail_nxt = tail_r; low_nxt = low_r; succ_nxt = succ_r;
    span_nxt = span_r; si_nxt = si_r; j_nxt = j_r; sa_nxt = sa_r; sb_nxt = sb_r;
    rend_nxt = rend_r; p_nxt = p_r; n_nxt = n_r; g_nxt = g_r; rcnt_nxt = rcnt_r;
    pv_nxt = pv_r; tip_nxt = tip_r; t_nxt = t_r; v_nxt = v_r; i_nxt = i_r;
    ok_nxt = ok_r; bad_nxt = bad_r; rot_nxt = rot_r;
    ov_nxt = ov_r && out_stall;
    opos_nxt = opos_r; olab_nxt = olab_r; ohas_nxt = ohas_r; olast_nxt = olast_r;
    mreq = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_WRITE) begin
            mreq.we = 1'b1; mreq.waddr = in_position; mreq.wdata = in_label;
          end else begin
            i_nxt = '0; ok_nxt = 1'b0; n_nxt = nn; g_nxt = gs;
            if (cfg_bad) begin
              bad_nxt = 1'b1; mreq.re = 1'b1; mreq.raddr = '0; state_nxt = S_OCAP;
            end else begin
              bad_nxt = 1'b0;
              if (cfg.group_size < CW'(2)) begin
                state_nxt = S_ORD;
              end else begin
                pivot_nxt = nn - gs - idx_t'(1);
                tail_nxt  = nn - idx_t'(1);
                low_nxt   = nn - gs - gs + idx_t'(1);
                mreq.re = 1'b1; mreq.raddr = AW'(nn - gs - idx_t'(1));
                state_nxt = S_APV;
              end
            end
          end
        end
      end
      S_APV: begin
        pv_nxt = mrdata; state_nxt = S_AT;
      end
      S_AT: begin
        if (tail_r > pivot_r) begin
          mreq.re = 1'b1; mreq.raddr = AW'(tail_r); state_nxt = S_ATC;
        end else begin
          state_nxt = S_AD;
        end
      end
      S_ATC: begin
        if (mrdata > pv_r) begin
          tail_nxt = tail_r - idx_t'(1); state_nxt = S_AT;
        end else begin
          state_nxt = S_AD;
        end
      end
      S_AD: begin
        if (tail_r + idx_t'(1) < n_r) begin
          sa_nxt = pivot_r; sb_nxt = tail_r + idx_t'(1); rot_nxt = 1'b0; state_nxt = S_SW0;
        end else begin
          state_nxt = S_BTOP;
        end
      end
      S_SW0: begin
        mreq.re = 1'b1; mreq.raddr = AW'(sa_r); state_nxt = S_SW1;
      end
      S_SW1: begin
        t_nxt = mrdata; mreq.re = 1'b1; mreq.raddr = AW'(sb_r); state_nxt = S_SW2;
      end
      S_SW2: begin
        mreq.we = 1'b1; mreq.waddr = AW'(sa_r); mreq.wdata = mrdata; state_nxt = S_SW3;
      end
      S_SW3: begin
        mreq.we = 1'b1; mreq.waddr = AW'(sb_r); mreq.wdata = t_r;
        if (rot_r) begin
          state_nxt = S_RINIT;
        end else begin
          ok_nxt = 1'b1; state_nxt = S_ORD;
        end
      end
      S_BTOP: begin
        if (pivot_r > idx_t'(0)) begin
          mreq.re = 1'b1; mreq.raddr = AW'(tail_r); state_nxt = S_BTIP;
        end else begin
          ok_nxt = 1'b0; state_nxt = S_ORD;
        end
      end
      S_BTIP: begin
        tip_nxt = mrdata; mreq.re = 1'b1; mreq.raddr = AW'(pivot_r); state_nxt = S_BPV;
      end
      S_BPV: begin
        pv_nxt = mrdata;
        if (pivot_r > low_r && tip_r < mrdata) begin
          pivot_nxt = pivot_r - idx_t'(1);
          mreq.re = 1'b1; mreq.raddr = AW'(pivot_r - idx_t'(1));
        end else if (tip_r > mrdata) begin
          succ_nxt = pivot_r + idx_t'(1);
          span_nxt = low_r + g_r - pivot_r - idx_t'(1);
          si_nxt   = pivot_r + idx_t'(2);
          state_nxt = S_SI;
        end else begin
          pivot_nxt = low_r - idx_t'(2);
          tail_nxt  = tail_r - g_r;
          low_nxt   = low_r - g_r;
          state_nxt = S_BTOP;
        end
      end
      S_SI: begin
        if (si_r < n_r) begin
          mreq.re = 1'b1; mreq.raddr = AW'(si_r); state_nxt = S_SV;
        end else begin
          state_nxt = S_FCHK;
        end
      end
      S_SV: begin
        v_nxt = mrdata; j_nxt = si_r - idx_t'(1); state_nxt = S_SJ;
      end
      S_SJ: begin
        if (j_r >= succ_r) begin
          mreq.re = 1'b1; mreq.raddr = AW'(j_r); state_nxt = S_SC;
        end else begin
          mreq.we = 1'b1; mreq.waddr = AW'(j_r + idx_t'(1)); mreq.wdata = v_r;
          si_nxt = si_r + idx_t'(1); state_nxt = S_SI;
        end
      end
      S_SC: begin
        mreq.we = 1'b1; mreq.waddr = AW'(j_r + idx_t'(1));
        if (mrdata > v_r) begin
          mreq.wdata = mrdata; j_nxt = j_r - idx_t'(1); state_nxt = S_SJ;
        end else begin
          mreq.wdata = v_r; si_nxt = si_r + idx_t'(1); state_nxt = S_SI;
        end
      end
      S_FCHK: begin
        if (succ_r < n_r - idx_t'(1)) begin
          mreq.re = 1'b1; mreq.raddr = AW'(succ_r); state_nxt = S_FC;
        end else begin
          sa_nxt = succ_r; sb_nxt = pivot_r; rot_nxt = 1'b1; state_nxt = S_SW0;
        end
      end
      S_FC: begin
        if (mrdata < pv_r) begin
          succ_nxt = succ_r + idx_t'(1); state_nxt = S_FCHK;
        end else begin
          sa_nxt = succ_r; sb_nxt = pivot_r; rot_nxt = 1'b1; state_nxt = S_SW0;
        end
      end
      S_RINIT: begin
        ok_nxt = 1'b1;
        if (rk <= idx_t'(0) || rk >= rlen) begin
          state_nxt = S_ORD;
        end else begin
          rcnt_nxt = rk; rend_nxt = rend_c; state_nxt = S_RA;
        end
      end
      S_RA: begin
        mreq.re = 1'b1; mreq.raddr = AW'(rfirst); state_nxt = S_RT;
      end
      S_RT: begin
        t_nxt = mrdata; p_nxt = rfirst; state_nxt = S_RP;
      end
      S_RP: begin
        if (p_r < rend_r - idx_t'(1)) begin
          mreq.re = 1'b1; mreq.raddr = AW'(p_r + idx_t'(1)); state_nxt = S_RW;
        end else begin
          mreq.we = 1'b1; mreq.waddr = AW'(rend_r - idx_t'(1)); mreq.wdata = t_r;
          rcnt_nxt = rcnt_r - idx_t'(1);
          state_nxt = (rcnt_r == idx_t'(1)) ? S_ORD : S_RA;
        end
      end
      S_RW: begin
        mreq.we = 1'b1; mreq.waddr = AW'(p_r); mreq.wdata = mrdata;
        p_nxt = p_r + idx_t'(1); state_nxt = S_RP;
      end
      S_ORD: begin
        mreq.re = 1'b1; mreq.raddr = i_r; state_nxt = S_OCAP;
      end
      S_OCAP: begin
        if (free) begin
          ov_nxt = 1'b1; opos_nxt = i_r; olab_nxt = mrdata;
          ohas_nxt = ok_r && !bad_r; olast_nxt = is_last;
          if (is_last) begin
            state_nxt = S_IDLE;
          end else begin
            i_nxt = i_r + AW'(1); state_nxt = S_ORD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pivot_r <= pivot_nxt; tail_r <= tail_nxt; low_r <= low_nxt; succ_r <= succ_nxt;
    span_r <= span_nxt; si_r <= si_nxt; j_r <= j_nxt; sa_r <= sa_nxt; sb_r <= sb_nxt;
    rend_r <= rend_nxt; p_r <= p_nxt; n_r <= n_nxt; g_r <= g_nxt; rcnt_r <= rcnt_nxt;
    pv_r <= pv_nxt; tip_r <= tip_nxt; t_r <= t_nxt; v_r <= v_nxt; i_r <= i_nxt;
    ok_r <= ok_nxt; bad_r <= bad_nxt; rot_r <= rot_nxt;
    opos_r <= opos_nxt; olab_r <= olab_nxt; ohas_r <= ohas_nxt; olast_r <= olast_nxt;
  end

  a_no_write_streaming: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ORD || state_r == S_OCAP) |-> !mreq.we)
    else $error("store written while streaming");
  a_advance_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_ADVANCE) |=> (state_r != S_IDLE))
    else $error("advance transaction did not start a sequence");
  a_bad_single: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !$past(ov_r && out_stall) && bad_r) |-> (olast_r && !ohas_r))
    else $error("bad configuration must give one closing transaction");
endmodule
`default_nettype wire

>>> src/next_equal_group_partition_unit.sv
// Top level of the equal-group partition unit: configuration registers, sequencer and store.
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | in_op, in_position, in_label
//  out     | output    | out_valid/out_stall | out_position, out_label, out_has_next, out_last
//  cfg     | input     | APB write/read    | group_size at 0x0, num_groups at 0x4
//
// A write transaction goes to the store without leaving the idle state. An advance scans for
// the pivot, sorts the tail and rotates a range, all paced by the single read port of the
// store, then streams the arrangement from the store. Reset sets the store to identity labels
// at once through per-entry valid bits. A stalled output holds the sequencer while the last
// result may wait in the output register as a new transaction is taken.
`timescale 1ns / 1ps
`default_nettype none
module next_equal_group_partition_unit #(
  parameter int MAX_N = negp_pkg::MAX_N_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_op,
  input  wire logic [negp_pkg::AW-1:0]  in_position,
  input  wire logic [negp_pkg::LW-1:0]  in_label,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [negp_pkg::AW-1:0]       out_position,
  output logic [negp_pkg::LW-1:0]       out_label,
  output logic                          out_has_next,
  output logic                          out_last,
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [2:0]               cfg_paddr,
  input  wire logic [31:0]              cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import negp_pkg::*;
  cfg_t          cfg_r;
  mem_req_t      mreq;
  logic [LW-1:0] mrdata;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_NUM_GROUPS) ? 32'(cfg_r.num_groups)
                                                       : 32'(cfg_r.group_size);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.group_size <= GROUP_SIZE_RST;
      cfg_r.num_groups <= NUM_GROUPS_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      if (cfg_paddr[2] == REG_GROUP_SIZE) begin
        cfg_r.group_size <= cfg_pwdata[CW-1:0];
      end else begin
        cfg_r.num_groups <= cfg_pwdata[CW-1:0];
      end
    end
  end

  negp_ctrl #(.MAX_N(MAX_N)) u_ctrl (
    .clk, .rst_n, .cfg(cfg_r),
    .in_valid, .in_stall, .in_op, .in_position, .in_label,
    .out_valid, .out_stall, .out_position, .out_label, .out_has_next, .out_last,
    .mreq, .mrdata
  );

  negp_mem u_mem (.clk, .rst_n, .req(mreq), .rdata(mrdata));
endmodule
`default_nettype wire
